### rtl/slkv_pkg.sv
// ----------------------------------------------------------------------------
// slkv_pkg
// shared types, constants and helpers of the skip list key-value store
// ----------------------------------------------------------------------------
package slkv_pkg;

    localparam int MAX_LEVEL  = 6;
    localparam int POOL_NODES = 256;

    localparam int NODE_W  = $clog2(POOL_NODES);
    localparam int ID_W    = NODE_W + 1;
    localparam int LVL_W   = $clog2(MAX_LEVEL + 1);
    localparam int LIDX_W  = $clog2(MAX_LEVEL);
    localparam int LINK_N  = POOL_NODES * MAX_LEVEL;
    localparam int LINK_AW = $clog2(LINK_N);
    localparam int FC_W    = $clog2(POOL_NODES + 1);

    localparam logic [ID_W-1:0]   HEAD_ID   = ID_W'(POOL_NODES);
    localparam logic [31:0]       INT_MAX   = 32'h7FFF_FFFF;
    localparam logic [15:0]       LFSR_MASK = 16'hB400;
    localparam logic [15:0]       SEED_RST  = 16'd44257;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_DELETED  = 3'd4,
        ST_REJECTED = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_LINK_RD, OP_LINK, OP_KEY, OP_VAL_RD, OP_VAL,
        OP_UPD, OP_PICK, OP_POP, OP_POP_D, OP_INS_NODE, OP_INS_RD,
        OP_INS_W1, OP_INS_W2, OP_DEL_RD1, OP_DEL_RD2, OP_DEL_W, OP_PUSH,
        OP_LOWER, OP_EMIT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_LINK_RD, S_LINK, S_KEY, S_DISPATCH, S_VAL_RD, S_VAL,
        S_UPD, S_PICK, S_POP, S_POP_D, S_INS_NODE, S_INS_RD, S_INS_W1,
        S_INS_W2, S_DEL_RD1, S_DEL_RD2, S_DEL_W, S_PUSH, S_LOWER, S_EMIT
    } t_state;

    typedef struct packed {
        t_op     op;
        t_status st;
        logic    in_ready;
    } t_cmd;

    typedef struct packed {
        logic       in_reject;
        logic [1:0] kind;
        logic       hit;
        logic       nxt_head;
        logic       key_less;
        logic       l_zero;
        logic       pool_empty;
        logic       pick_stop;
        logic       pop_fresh;
        logic       pred_head;
        logic       ins_last;
        logic       del_match;
        logic       del_last;
        logic       lower_more;
        logic       out_free;
    } t_stat;

    function automatic logic [LINK_AW-1:0] link_addr(input logic [NODE_W-1:0] node,
                                                     input logic [LIDX_W-1:0] lvl);
        link_addr = LINK_AW'(node) * LINK_AW'(MAX_LEVEL) + LINK_AW'(lvl);
    endfunction

endpackage

### rtl/slkv_ram.sv
// ----------------------------------------------------------------------------
// slkv_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module slkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/slkv_ctrl.sv
// ----------------------------------------------------------------------------
// slkv_ctrl
// operation sequencer: walk, then insert, search or delete steps
// ----------------------------------------------------------------------------
module slkv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  slkv_pkg::t_stat i_stat,
    output slkv_pkg::t_cmd  o_cmd
);
    import slkv_pkg::*;

    t_state  r_state, n_state;
    t_status r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_REJECTED;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.in_reject) begin
                        n_st    = ST_REJECTED;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_LINK_RD;
                    end
                end
            end
            S_LINK_RD: n_state = S_LINK;
            S_LINK: begin
                if (!i_stat.nxt_head) n_state = S_KEY;
                else if (i_stat.l_zero) n_state = S_DISPATCH;
                else n_state = S_LINK_RD;
            end
            S_KEY: begin
                if (i_stat.key_less || !i_stat.l_zero) n_state = S_LINK_RD;
                else n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_stat.kind == KIND_SEARCH) begin
                    if (i_stat.hit) n_state = S_VAL_RD;
                    else begin
                        n_st    = ST_MISSING;
                        n_state = S_EMIT;
                    end
                end else if (i_stat.kind == KIND_INSERT) begin
                    if (i_stat.hit) n_state = S_UPD;
                    else if (i_stat.pool_empty) begin
                        n_st    = ST_REJECTED;
                        n_state = S_EMIT;
                    end else n_state = S_PICK;
                end else begin
                    if (i_stat.hit) n_state = S_DEL_RD1;
                    else begin
                        n_st    = ST_MISSING;
                        n_state = S_EMIT;
                    end
                end
            end
            S_VAL_RD: n_state = S_VAL;
            S_VAL: begin
                n_st    = ST_FOUND;
                n_state = S_EMIT;
            end
            S_UPD: begin
                n_st    = ST_UPDATED;
                n_state = S_EMIT;
            end
            S_PICK: if (i_stat.pick_stop) n_state = S_POP;
            S_POP: n_state = i_stat.pop_fresh ? S_INS_NODE : S_POP_D;
            S_POP_D: n_state = S_INS_NODE;
            S_INS_NODE: n_state = S_INS_RD;
            S_INS_RD: n_state = S_INS_W1;
            S_INS_W1: begin
                if (!i_stat.pred_head) n_state = S_INS_W2;
                else if (i_stat.ins_last) begin
                    n_st    = ST_INSERTED;
                    n_state = S_EMIT;
                end else n_state = S_INS_RD;
            end
            S_INS_W2: begin
                if (i_stat.ins_last) begin
                    n_st    = ST_INSERTED;
                    n_state = S_EMIT;
                end else n_state = S_INS_RD;
            end
            S_DEL_RD1: n_state = S_DEL_RD2;
            S_DEL_RD2: n_state = i_stat.del_match ? S_DEL_W : S_PUSH;
            S_DEL_W: n_state = i_stat.del_last ? S_PUSH : S_DEL_RD1;
            S_PUSH: n_state = S_LOWER;
            S_LOWER: begin
                if (!i_stat.lower_more) begin
                    n_st    = ST_DELETED;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.st       = r_st;
        o_cmd.in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_LINK_RD:  o_cmd.op = OP_LINK_RD;
            S_LINK:     o_cmd.op = OP_LINK;
            S_KEY:      o_cmd.op = OP_KEY;
            S_VAL_RD:   o_cmd.op = OP_VAL_RD;
            S_VAL:      o_cmd.op = OP_VAL;
            S_UPD:      o_cmd.op = OP_UPD;
            S_PICK:     o_cmd.op = OP_PICK;
            S_POP:      o_cmd.op = OP_POP;
            S_POP_D:    o_cmd.op = OP_POP_D;
            S_INS_NODE: o_cmd.op = OP_INS_NODE;
            S_INS_RD:   o_cmd.op = OP_INS_RD;
            S_INS_W1:   o_cmd.op = OP_INS_W1;
            S_INS_W2:   o_cmd.op = OP_INS_W2;
            S_DEL_RD1:  o_cmd.op = OP_DEL_RD1;
            S_DEL_RD2:  o_cmd.op = OP_DEL_RD2;
            S_DEL_W:    o_cmd.op = OP_DEL_W;
            S_PUSH:     o_cmd.op = OP_PUSH;
            S_LOWER:    o_cmd.op = OP_LOWER;
            S_EMIT:     if (i_stat.out_free) o_cmd.op = OP_EMIT;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

endmodule

### rtl/slkv_dp.sv
// ----------------------------------------------------------------------------
// slkv_dp
// node memories, head links, free stack, level lfsr and result register
// ----------------------------------------------------------------------------
module slkv_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  slkv_pkg::t_cmd  i_cmd,
    output slkv_pkg::t_stat o_stat,
    input  logic [1:0]      i_kind,
    input  logic [31:0]     i_key,
    input  logic [31:0]     i_value,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [2:0]      o_status,
    output logic [31:0]     o_found_value
);
    import slkv_pkg::*;

    logic [1:0]         r_kind;
    logic signed [31:0] r_key;
    logic [31:0]        r_val;
    logic [ID_W-1:0]    r_x;
    logic [LIDX_W-1:0]  r_l;
    logic [ID_W-1:0]    r_pred [MAX_LEVEL];
    logic [ID_W-1:0]    r_head [MAX_LEVEL];
    logic [ID_W-1:0]    r_nxt;
    logic [NODE_W-1:0]  r_c;
    logic               r_hit;
    logic [LVL_W-1:0]   r_lvl;
    logic [LVL_W-1:0]   r_nlvl;
    logic [NODE_W-1:0]  r_n;
    logic [FC_W-1:0]    r_fc;
    logic [FC_W-1:0]    r_low;
    logic [15:0]        r_lfsr;
    logic [31:0]        r_fval;
    logic               r_ovalid;
    logic [2:0]         r_ostat;
    logic [31:0]        r_oval;

    logic [31:0]        key_rdata, val_rdata;
    logic [ID_W-1:0]    link_rdata;
    logic [NODE_W-1:0]  free_rdata;
    logic [ID_W-1:0]    nxt_w, pred_l, head_l;
    logic [LINK_AW-1:0] link_raddr, link_waddr;
    logic               link_we;
    logic [ID_W-1:0]    link_wdata;
    logic [FC_W-1:0]    fc_m1;
    logic [15:0]        lfsr_nxt;
    logic               key_eq, key_less;

    assign head_l   = r_head[r_l];
    assign pred_l   = r_pred[r_l];
    assign nxt_w    = (r_x == HEAD_ID) ? head_l : link_rdata;
    assign fc_m1    = r_fc - FC_W'(1);
    assign key_eq   = $signed(key_rdata) == r_key;
    assign key_less = $signed(key_rdata) < r_key;
    assign lfsr_nxt = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : 16'h0000);

    always_comb begin
        o_stat.in_reject  = (i_kind == KIND_UNUSED) ||
                            (i_kind == KIND_INSERT && i_key == INT_MAX);
        o_stat.kind       = r_kind;
        o_stat.hit        = r_hit;
        o_stat.nxt_head   = nxt_w == HEAD_ID;
        o_stat.key_less   = key_less;
        o_stat.l_zero     = r_l == '0;
        o_stat.pool_empty = r_fc == '0;
        o_stat.pick_stop  = !r_lfsr[0] || (r_nlvl >= LVL_W'(MAX_LEVEL));
        o_stat.pop_fresh  = fc_m1 < r_low;
        o_stat.pred_head  = pred_l == HEAD_ID;
        o_stat.ins_last   = r_l == LIDX_W'(r_nlvl - LVL_W'(1));
        o_stat.del_match  = ((pred_l == HEAD_ID) ? head_l : link_rdata) == ID_W'(r_c);
        o_stat.del_last   = r_l == LIDX_W'(r_lvl - LVL_W'(1));
        o_stat.lower_more = (r_lvl > LVL_W'(1)) &&
                            (r_head[LIDX_W'(r_lvl - LVL_W'(1))] == HEAD_ID);
        o_stat.out_free   = !r_ovalid || i_out_ready;
    end

    // link memory port selection
    always_comb begin
        link_raddr = link_addr(r_x[NODE_W-1:0], r_l);
        link_we    = 1'b0;
        link_waddr = link_addr(pred_l[NODE_W-1:0], r_l);
        link_wdata = link_rdata;
        case (i_cmd.op)
            OP_INS_RD, OP_DEL_RD1: link_raddr = link_addr(pred_l[NODE_W-1:0], r_l);
            OP_DEL_RD2: link_raddr = link_addr(r_c, r_l);
            OP_INS_W1: begin
                link_we    = 1'b1;
                link_waddr = link_addr(r_n, r_l);
                link_wdata = (pred_l == HEAD_ID) ? head_l : link_rdata;
            end
            OP_INS_W2: begin
                link_we    = 1'b1;
                link_wdata = ID_W'(r_n);
            end
            OP_DEL_W: link_we = pred_l != HEAD_ID;
            default: link_we = 1'b0;
        endcase
    end

    slkv_ram #(.WIDTH(32), .DEPTH(POOL_NODES)) u_keys (
        .i_clk(i_clk), .i_we(i_cmd.op == OP_INS_NODE), .i_waddr(r_n),
        .i_wdata(r_key), .i_raddr(nxt_w[NODE_W-1:0]), .o_rdata(key_rdata)
    );

    slkv_ram #(.WIDTH(32), .DEPTH(POOL_NODES)) u_vals (
        .i_clk(i_clk), .i_we(i_cmd.op == OP_INS_NODE || i_cmd.op == OP_UPD),
        .i_waddr((i_cmd.op == OP_UPD) ? r_c : r_n), .i_wdata(r_val),
        .i_raddr(r_c), .o_rdata(val_rdata)
    );

    slkv_ram #(.WIDTH(ID_W), .DEPTH(LINK_N)) u_links (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr),
        .i_wdata(link_wdata), .i_raddr(link_raddr), .o_rdata(link_rdata)
    );

    slkv_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_free (
        .i_clk(i_clk), .i_we(i_cmd.op == OP_PUSH && r_fc < FC_W'(POOL_NODES)),
        .i_waddr(r_fc[NODE_W-1:0]), .i_wdata(r_c),
        .i_raddr(fc_m1[NODE_W-1:0]), .o_rdata(free_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEVEL; i++) r_head[i] <= HEAD_ID;
            r_lvl    <= LVL_W'(1);
            r_fc     <= FC_W'(POOL_NODES);
            r_low    <= FC_W'(POOL_NODES);
            r_lfsr   <= SEED_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_lfsr <= i_cfg_data;
            if (i_cmd.op == OP_EMIT) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
            case (i_cmd.op)
                OP_LOAD: begin
                    r_kind <= i_kind;
                    r_key  <= $signed(i_key);
                    r_val  <= i_value;
                    r_x    <= HEAD_ID;
                    r_l    <= LIDX_W'(r_lvl - LVL_W'(1));
                    r_nlvl <= LVL_W'(1);
                    r_fval <= '0;
                    r_hit  <= 1'b0;
                end
                OP_LINK: begin
                    r_nxt <= nxt_w;
                    if (nxt_w == HEAD_ID) begin
                        r_pred[r_l] <= r_x;
                        r_hit       <= 1'b0;
                        if (r_l != '0) r_l <= r_l - LIDX_W'(1);
                    end
                end
                OP_KEY: begin
                    if (key_less) r_x <= r_nxt;
                    else begin
                        r_pred[r_l] <= r_x;
                        r_hit       <= key_eq;
                        r_c         <= r_nxt[NODE_W-1:0];
                        if (r_l != '0) r_l <= r_l - LIDX_W'(1);
                    end
                end
                OP_VAL: r_fval <= val_rdata;
                OP_PICK: begin
                    r_lfsr <= lfsr_nxt;
                    if (r_lfsr[0] && r_nlvl < LVL_W'(MAX_LEVEL)) r_nlvl <= r_nlvl + LVL_W'(1);
                end
                OP_POP: begin
                    r_fc <= fc_m1;
                    if (fc_m1 < r_low) begin
                        r_n   <= fc_m1[NODE_W-1:0];
                        r_low <= fc_m1;
                    end
                end
                OP_POP_D: r_n <= free_rdata;
                OP_INS_NODE: begin
                    r_l <= '0;
                    if (r_nlvl > r_lvl) begin
                        for (int i = 0; i < MAX_LEVEL; i++) begin
                            if (LVL_W'(i) >= r_lvl && LVL_W'(i) < r_nlvl) r_pred[i] <= HEAD_ID;
                        end
                        r_lvl <= r_nlvl;
                    end
                end
                OP_INS_W1: begin
                    if (pred_l == HEAD_ID) begin
                        r_head[r_l] <= ID_W'(r_n);
                        r_l         <= r_l + LIDX_W'(1);
                    end
                end
                OP_INS_W2: r_l <= r_l + LIDX_W'(1);
                OP_DEL_RD1: ;
                OP_DEL_W: begin
                    if (pred_l == HEAD_ID) r_head[r_l] <= link_rdata;
                    r_l <= r_l + LIDX_W'(1);
                end
                OP_PUSH: begin
                    r_l <= '0;
                    if (r_fc < FC_W'(POOL_NODES)) r_fc <= r_fc + FC_W'(1);
                end
                OP_LOWER: if (o_stat.lower_more) r_lvl <= r_lvl - LVL_W'(1);
                OP_EMIT: begin
                    r_ostat <= i_cmd.st;
                    r_oval  <= (i_cmd.st == ST_FOUND) ? r_fval : 32'd0;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostat;
    assign o_found_value = r_oval;

endmodule

### rtl/skip_list_key_value_store.sv
// ----------------------------------------------------------------------------
// skip_list_key_value_store
// ordered key-value store kept as a skip list in a fixed pool of nodes
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 contents
//  s_axis    in   i_s_tvalid / o_s_tready   tuser kind, tdata key and value
//  m_axis    out  o_m_tvalid / i_m_tready   tuser status, tdata found value
//  cfg       in   i_cfg_we                  level lfsr seed
//
//  one operation at a time; each level ends after a link read plus a key
//  compare when the link is not the header, and each hop costs a link read
//  and a key compare; inserts add a pick step per lfsr bit and a link read
//  and up to two link writes per linked level, deletes two link reads and a
//  link write per unlinked level plus level lowering
//  no clearing pass after reset; the free stack uses a low watermark
//  a finished result waits in the output register while the next beat is taken
// ----------------------------------------------------------------------------
module skip_list_key_value_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // key [31:0], value [63:32]
    input  logic [1:0]  i_s_tuser,   // kind [1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // found_value [31:0]
    output logic [2:0]  o_m_tuser,   // status [2:0]
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    import slkv_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: walk down the levels, then run the operation steps
    slkv_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_s_tvalid),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // memories, links, free stack, lfsr and output register
    slkv_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_kind       (i_s_tuser),
        .i_key        (i_s_tdata[31:0]),
        .i_value      (i_s_tdata[63:32]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_status     (o_m_tuser),
        .o_found_value(o_m_tdata)
    );

    // ready only while the sequencer is idle
    assign o_s_tready = cmd.in_ready;

endmodule

### rtl/slkv_check.sv
// ----------------------------------------------------------------------------
// slkv_check
// port-level checks of the skip list store, bound to the top level
// ----------------------------------------------------------------------------
module slkv_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [2:0]  o_m_tuser
);
    import slkv_pkg::*;

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser <= ST_REJECTED)
        else $error("bad status code");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_FOUND |-> o_m_tdata == 32'd0)
        else $error("value without a hit");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("beat taken while busy");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind skip_list_key_value_store slkv_check u_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready), .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
);
